// File: hw/rtl/arrset_pkg.sv
// ----------------------------------------------------------------------------
// arrset_pkg
// Shared types and constants for the unordered array set block.
// ----------------------------------------------------------------------------
package arrset_pkg;

    localparam int CAPACITY   = 64;
    localparam int ELEM_WIDTH = 32;
    localparam int IDX_WIDTH  = $clog2(CAPACITY);
    localparam int CNT_WIDTH  = $clog2(CAPACITY + 1);

    localparam int OP_WIDTH     = 2;
    localparam int STATUS_WIDTH = 2;

    // beat layouts, padded to whole bytes
    localparam int S_DATA_BITS  = OP_WIDTH + ELEM_WIDTH;
    localparam int S_DATA_WIDTH = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS  = 1 + CNT_WIDTH + 1 + 1 + STATUS_WIDTH;
    localparam int M_DATA_WIDTH = ((M_DATA_BITS + 7) / 8) * 8;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_DONE      = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_REJECTED  = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic search;
        logic shift;
        logic commit;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic search_done;
        logic hit;
        logic is_delete;
        logic shift_done;
        logic out_free;
    } dp_status_t;

endpackage

// File: hw/rtl/arrset_ctrl.sv
// ----------------------------------------------------------------------------
// arrset_ctrl
// Request sequencer: accept, search, compact on delete, then commit.
// ----------------------------------------------------------------------------
module arrset_ctrl
    import arrset_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t st
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                cmd.search = 1'b1;
                if (st.search_done) begin
                    state_next = (st.hit && st.is_delete) ? S_SHIFT : S_COMMIT;
                end
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (st.shift_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (st.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/arrset_dp.sv
// ----------------------------------------------------------------------------
// arrset_dp
// Entry memory, fill count, search/compaction pointers and result register.
// ----------------------------------------------------------------------------
module arrset_dp
    import arrset_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [S_DATA_WIDTH-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_DATA_WIDTH-1:0] m_tdata,
    input  ctrl_cmd_t               cmd,
    output dp_status_t              st
);

    logic [ELEM_WIDTH-1:0] mem [CAPACITY];
    logic [ELEM_WIDTH-1:0] rd_data_reg;

    op_t                   op_reg;
    logic [ELEM_WIDTH-1:0] elem_reg;
    logic [CNT_WIDTH-1:0]  count_reg;
    logic [CNT_WIDTH-1:0]  count_next;
    logic [CNT_WIDTH-1:0]  idx_reg;
    logic [CNT_WIDTH-1:0]  pend_idx_reg;
    logic                  pend_reg;
    logic                  found_reg;

    logic                  out_valid_reg;
    logic [M_DATA_WIDTH-1:0] out_data_reg;

    logic                  hit;
    logic                  issue;
    logic                  wr_en;
    logic [IDX_WIDTH-1:0]  wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;
    logic [CNT_WIDTH-1:0]  pend_prev;
    status_t               status_next;
    logic                  ins_ok;

    // read data belongs to the entry at pend_idx_reg
    assign hit       = pend_reg && (rd_data_reg == elem_reg);
    assign issue     = idx_reg < count_reg;
    assign pend_prev = pend_idx_reg - CNT_WIDTH'(1);
    assign ins_ok    = (op_reg == OP_INSERT) && !found_reg && (count_reg < CNT_WIDTH'(CAPACITY));

    assign st.hit         = hit;
    assign st.search_done = hit || (!pend_reg && !issue);
    assign st.shift_done  = !pend_reg && !issue;
    assign st.is_delete   = (op_reg == OP_DELETE);
    assign st.out_free    = !out_valid_reg || m_tready;

    // single write port: compaction moves or the insert append
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_WIDTH-1:0];
        wr_data = elem_reg;
        if (cmd.shift && pend_reg) begin
            wr_en   = 1'b1;
            wr_addr = pend_prev[IDX_WIDTH-1:0];
            wr_data = rd_data_reg;
        end else if (cmd.commit && ins_ok) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg[IDX_WIDTH-1:0]];
    end

    always_comb begin
        count_next  = count_reg;
        status_next = ST_DONE;
        case (op_reg)
            OP_INSERT: begin
                if (found_reg) begin
                    status_next = ST_NO_CHANGE;
                end else if (!ins_ok) begin
                    status_next = ST_REJECTED;
                end else begin
                    count_next = count_reg + CNT_WIDTH'(1);
                end
            end
            OP_DELETE: begin
                if (found_reg) begin
                    count_next = count_reg - CNT_WIDTH'(1);
                end else begin
                    status_next = ST_NO_CHANGE;
                end
            end
            OP_QUERY: begin
                status_next = ST_DONE;
            end
            default: begin
                status_next = (count_reg != '0) ? ST_DONE : ST_NO_CHANGE;
                count_next  = '0;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= op_t'(s_tdata[OP_WIDTH-1:0]);
            elem_reg <= s_tdata[OP_WIDTH +: ELEM_WIDTH];
        end
        if (cmd.search && !hit) begin
            pend_idx_reg <= idx_reg;
        end else if (cmd.shift) begin
            pend_idx_reg <= idx_reg;
        end
        if (cmd.commit) begin
            out_data_reg <= M_DATA_WIDTH'({status_next,
                                           count_next == '0,
                                           count_next == CNT_WIDTH'(CAPACITY),
                                           count_next,
                                           found_reg});
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                idx_reg   <= '0;
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end else if (cmd.search) begin
                if (hit) begin
                    // compaction starts from the entry after the match
                    found_reg <= 1'b1;
                    pend_reg  <= 1'b0;
                    idx_reg   <= pend_idx_reg + CNT_WIDTH'(1);
                end else begin
                    pend_reg <= issue;
                    if (issue) begin
                        idx_reg <= idx_reg + CNT_WIDTH'(1);
                    end
                end
            end else if (cmd.shift) begin
                pend_reg <= issue;
                if (issue) begin
                    idx_reg <= idx_reg + CNT_WIDTH'(1);
                end
            end
            if (cmd.commit) begin
                count_reg <= count_next;
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: hw/rtl/array_set_insert_delete_member.sv
// ----------------------------------------------------------------------------
// array_set_insert_delete_member
// Bounded set of distinct values held packed in an on-chip array.
// ----------------------------------------------------------------------------
// Keeps up to CAPACITY (64) distinct 32-bit values packed from entry 0 plus a
// fill count. Each input beat carries an operation (insert, delete, query,
// clear) and an element; each yields exactly one output beat with the prior
// membership, the new count, full/empty flags and a status (0 done,
// 1 no change needed, 2 insert rejected as full). One request is worked at a
// time. Every request first walks the held entries through the single memory
// read port, one entry a cycle, stopping at a match. A delete that hits then
// moves each later entry down one place, again one a cycle; as the search
// stopped at the match, the two walks together pass over the held entries
// only once. After each commit the sequencer passes through idle before the
// next request is taken, and that request is taken while a finished result
// still waits on m_tready. Memory contents need no clearing after reset; only
// entries below the count are ever compared.
// ----------------------------------------------------------------------------
module array_set_insert_delete_member
    import arrset_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // request beats
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_DATA_WIDTH-1:0] s_tdata,  // [1:0] op, [33:2] element, rest zero
    // result beats
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_DATA_WIDTH-1:0] m_tdata   // [0] was_member, [7:1] count,
                                              // [8] is_full, [9] is_empty,
                                              // [11:10] status, rest zero
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    // sequencer: one request in flight, steps the datapath through its phases
    arrset_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .st       (st)
    );

    // storage, search/compaction pointers and the output register
    arrset_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded array set (insert, delete, query, clear).
// ----------------------------------------------------------------------------
// Request beats go in on the s_ side and result beats come back on the m_ side.
// The bench keeps its own shadow copy of the packed set and predicts each
// result at the moment its request is accepted. Every result beat is then
// compared field by field with the oldest prediction.
// Directed beats cover the edge values and each special case. A fill pass
// drives the set to capacity and past it. Random traffic follows, with
// growing, shrinking and mixed phases drawn from a small value pool so that
// hits are common. Both sides idle at random, apart from one steady stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import arrset_pkg::*;

    localparam int IDLE_PCT       = 11;
    localparam int WATCHDOG_LIMIT = 5000;  // covers the worst beat plus stalls
    localparam int TAIL_CYCLES    = 150;
    localparam int MAX_PRINTS     = 40;

    typedef struct {
        logic                 was_member;
        logic [CNT_WIDTH-1:0] count;
        logic                 is_full;
        logic                 is_empty;
        status_t              status;
    } set_result_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_DATA_WIDTH-1:0] s_tdata  = '0;  // [1:0] op, [33:2] element, rest zero
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_DATA_WIDTH-1:0] m_tdata;        // [0] was_member, [7:1] count, [8] is_full,
                                             // [9] is_empty, [11:10] status, rest zero

    // shadow of the set contents, packed from entry 0
    logic [ELEM_WIDTH-1:0] held_vals [CAPACITY];
    int                    held_count = 0;

    set_result_t pending_results[$];

    bit steady_stream = 1'b0;  // suppresses idling on both sides
    bit timed_out     = 1'b0;
    int mismatches    = 0;
    int idle_cycles   = 0;

    // run statistics for the summary
    int ops_seen [4];
    int hits_seen     = 0;
    int rejects_seen  = 0;
    int peak_fill     = 0;

    array_set_insert_delete_member u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction: apply one request to the shadow set, return its result
    // ------------------------------------------------------------------
    function automatic set_result_t apply_request(op_t op, logic [ELEM_WIDTH-1:0] elem);
        set_result_t r;
        int          slot;
        status_t     st;
        slot = -1;
        for (int i = 0; i < held_count; i++) begin
            if (held_vals[i] == elem) begin
                slot = i;
                break;
            end
        end
        case (op)
            OP_INSERT: begin
                if (slot >= 0) begin
                    st = ST_NO_CHANGE;
                end else if (held_count >= CAPACITY) begin
                    st = ST_REJECTED;
                end else begin
                    held_vals[held_count] = elem;
                    held_count++;
                    st = ST_DONE;
                end
            end
            OP_DELETE: begin
                if (slot < 0) begin
                    st = ST_NO_CHANGE;
                end else begin
                    // later entries close the gap, order kept
                    for (int i = slot; i + 1 < held_count; i++)
                        held_vals[i] = held_vals[i + 1];
                    held_count--;
                    st = ST_DONE;
                end
            end
            OP_QUERY: begin
                st = ST_DONE;
            end
            default: begin
                st = (held_count != 0) ? ST_DONE : ST_NO_CHANGE;
                held_count = 0;
            end
        endcase
        r.was_member = (slot >= 0);
        r.count      = CNT_WIDTH'(held_count);
        r.is_full    = (held_count == CAPACITY);
        r.is_empty   = (held_count == 0);
        r.status     = st;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side: one beat, with random gaps ahead of it
    // ------------------------------------------------------------------
    task automatic send_request(op_t op, logic [ELEM_WIDTH-1:0] elem);
        set_result_t r;
        @(negedge aclk);
        while (!steady_stream && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_WIDTH - S_DATA_BITS){1'b0}}, elem, op};
        do @(posedge aclk); while (!s_tready);
        r = apply_request(op, elem);
        pending_results.push_back(r);
        ops_seen[op]++;
        if (r.was_member)            hits_seen++;
        if (r.status == ST_REJECTED) rejects_seen++;
        if (held_count > peak_fill)  peak_fill = held_count;
    endtask

    // sender holds off until every outstanding result is back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, checking on each accepted beat
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        m_tready <= steady_stream || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        set_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", 32'(m_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.was_member)
                    report_mismatch("was_member", 32'(m_tdata[0]), 32'(want.was_member));
                if (m_tdata[CNT_WIDTH:1] !== want.count)
                    report_mismatch("count", 32'(m_tdata[CNT_WIDTH:1]), 32'(want.count));
                if (m_tdata[CNT_WIDTH+1] !== want.is_full)
                    report_mismatch("is_full", 32'(m_tdata[CNT_WIDTH+1]),
                                    32'(want.is_full));
                if (m_tdata[CNT_WIDTH+2] !== want.is_empty)
                    report_mismatch("is_empty", 32'(m_tdata[CNT_WIDTH+2]),
                                    32'(want.is_empty));
                if (m_tdata[CNT_WIDTH+3 +: STATUS_WIDTH] !== want.status)
                    report_mismatch("status", 32'(m_tdata[CNT_WIDTH+3 +: STATUS_WIDTH]),
                                    32'(want.status));
            end
        end
    end

    task automatic conclude();
        if (mismatches == 0 && !timed_out)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    endtask

    // ------------------------------------------------------------------
    // Watchdog: too long with no beat on either side ends the run
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, pending_results.size());
            timed_out = 1'b1;
            conclude();
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // empty-set corner cases, extreme element values, duplicates, clears
    task automatic test_edge_cases();
        send_request(OP_QUERY,  32'h0000_0000);  // query on empty set
        send_request(OP_DELETE, 32'h0000_0000);  // delete of absent element
        send_request(OP_CLEAR,  32'hFFFF_FFFF);  // clear of empty set
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0000);  // already present
        send_request(OP_INSERT, 32'hA5A5_5A5A);
        send_request(OP_QUERY,  32'hFFFF_FFFF);
        send_request(OP_QUERY,  32'h5A5A_A5A5);  // absent
        send_request(OP_DELETE, 32'h0000_0000);  // first entry, rest moves down
        send_request(OP_QUERY,  32'hA5A5_5A5A);
        send_request(OP_DELETE, 32'h1234_5678);  // absent
        send_request(OP_DELETE, 32'hA5A5_5A5A);  // last entry
        send_request(OP_INSERT, 32'h8000_0001);
        send_request(OP_CLEAR,  32'hFFFF_FFFF);  // non-empty, element held
        send_request(OP_INSERT, 32'h7FFF_FFFE);
        send_request(OP_CLEAR,  32'h0000_0001);  // non-empty, element absent
        send_request(OP_QUERY,  32'h7FFF_FFFE);  // gone after clear
    endtask

    // fill to capacity, push past it, punch holes, refill
    task automatic test_fill_and_overflow();
        logic [ELEM_WIDTH-1:0] fill_vals [CAPACITY];
        logic [ELEM_WIDTH-1:0] spare;
        for (int i = 0; i < CAPACITY; i++)
            fill_vals[i] = {26'($urandom), 6'(i)};  // low bits keep them distinct
        spare = fill_vals[0] ^ 32'h8000_0000;
        send_request(OP_CLEAR, 32'h0);
        for (int i = 0; i < CAPACITY; i++)
            send_request(OP_INSERT, fill_vals[i]);
        send_request(OP_INSERT, spare);                 // refused, set full
        send_request(OP_INSERT, fill_vals[10]);         // present while full
        send_request(OP_QUERY,  fill_vals[CAPACITY-1]);
        send_request(OP_DELETE, fill_vals[0]);          // first
        send_request(OP_DELETE, fill_vals[CAPACITY-1]); // last
        send_request(OP_DELETE, fill_vals[30]);         // middle
        send_request(OP_QUERY,  fill_vals[31]);
        send_request(OP_INSERT, spare);
        send_request(OP_INSERT, fill_vals[30]);
        send_request(OP_INSERT, fill_vals[0]);          // full again
        send_request(OP_INSERT, fill_vals[CAPACITY-1]); // refused
        send_request(OP_CLEAR,  fill_vals[5]);          // clear from full
    endtask

    // phased random traffic over a value pool that drifts slowly
    task automatic test_random_traffic(int n_blocks);
        logic [ELEM_WIDTH-1:0] pool [96];
        logic [ELEM_WIDTH-1:0] elem;
        int                    mode;
        int                    pick;
        op_t                   op;
        for (int i = 0; i < 96; i++) pool[i] = $urandom;
        for (int b = 0; b < n_blocks; b++) begin
            steady_stream = (b == 4 || b == 5);
            mode = $urandom_range(2);  // 0 grow, 1 shrink, 2 mixed
            for (int i = 0; i < 16; i++) pool[$urandom_range(95)] = $urandom;
            for (int k = 0; k < 100; k++) begin
                pick = $urandom_range(99);
                case (mode)
                    0:       op = (pick < 70) ? OP_INSERT : (pick < 80) ? OP_DELETE :
                                  (pick < 98) ? OP_QUERY  : OP_CLEAR;
                    1:       op = (pick < 20) ? OP_INSERT : (pick < 75) ? OP_DELETE :
                                  (pick < 98) ? OP_QUERY  : OP_CLEAR;
                    default: op = (pick < 40) ? OP_INSERT : (pick < 70) ? OP_DELETE :
                                  (pick < 95) ? OP_QUERY  : OP_CLEAR;
                endcase
                // mostly pool values so hits are frequent, some wide random
                if ($urandom_range(9) == 0) elem = $urandom;
                else                        elem = pool[$urandom_range(95)];
                send_request(op, elem);
            end
            // every few blocks let the set settle completely
            if (b % 3 == 2) drain_results();
        end
        steady_stream = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < 4; i++) ops_seen[i] = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_edge_cases();
        drain_results();
        test_fill_and_overflow();
        drain_results();
        test_random_traffic(12);
        drain_results();

        // allow any trailing beat to surface
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d inserts, %0d deletes, %0d queries, %0d clears",
                 ops_seen[OP_INSERT], ops_seen[OP_DELETE], ops_seen[OP_QUERY],
                 ops_seen[OP_CLEAR]);
        $display("hits %0d, inserts refused as full %0d, peak fill %0d of %0d",
                 hits_seen, rejects_seen, peak_fill, CAPACITY);
        conclude();
    end

endmodule
